[sv/utf8d_pkg.sv]
// Package for the UTF-8 to UTF-32 decoder: byte classes, queue item type
// and the numeric limits of the decoder. No dependencies.
`default_nettype none

package utf8d_pkg;

  localparam int unsigned CpW  = 21;
  localparam int unsigned LenW = 3;

  localparam logic [CpW-1:0] CpMax       = 21'h10FFFF;
  localparam logic [CpW-1:0] SurrLo      = 21'h00D800;
  localparam logic [CpW-1:0] SurrHi      = 21'h00DFFF;
  localparam logic [CpW-1:0] Min2Byte    = 21'h000080;
  localparam logic [CpW-1:0] Min3Byte    = 21'h000800;
  localparam logic [CpW-1:0] Min4Byte    = 21'h010000;

  localparam logic [LenW-1:0] Len1 = 3'd1;
  localparam logic [LenW-1:0] Len2 = 3'd2;
  localparam logic [LenW-1:0] Len3 = 3'd3;
  localparam logic [LenW-1:0] Len4 = 3'd4;

  typedef enum logic [2:0] {
    KIND_ASCII,
    KIND_LEAD2,
    KIND_LEAD3,
    KIND_LEAD4,
    KIND_CONT,
    KIND_BAD
  } byte_kind_e;

  typedef struct packed {
    logic       cmd;
    byte_kind_e kind;
    logic [7:0] data;
  } item_t;

endpackage

`default_nettype wire

[sv/utf8d_front.sv]
// Front end of the UTF-8 decoder: sorts each incoming byte into its class.
// Depends on utf8d_pkg.
`default_nettype none

module utf8d_front (
  input  logic          command_i,
  input  logic [7:0]    data_byte_i,
  output utf8d_pkg::item_t item_o
);
  import utf8d_pkg::*;

  byte_kind_e kind;

  always_comb begin
    if (data_byte_i inside {[8'h00:8'h7F]}) begin
      kind = KIND_ASCII;
    end else if (data_byte_i inside {[8'h80:8'hBF]}) begin
      kind = KIND_CONT;
    end else if (data_byte_i inside {[8'hC2:8'hDF]}) begin
      kind = KIND_LEAD2;
    end else if (data_byte_i inside {[8'hE0:8'hEF]}) begin
      kind = KIND_LEAD3;
    end else if (data_byte_i inside {[8'hF0:8'hF4]}) begin
      kind = KIND_LEAD4;
    end else begin
      kind = KIND_BAD;
    end
  end

  assign item_o = '{cmd: command_i, kind: kind, data: data_byte_i};

endmodule

`default_nettype wire

[sv/utf8d_fifo.sv]
// Short queue of classified bytes between the decoder front and back ends.
// Depends on utf8d_pkg.
`default_nettype none

module utf8d_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  utf8d_pkg::item_t push_item_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output utf8d_pkg::item_t pop_item_o
);
  import utf8d_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  item_t            mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

[sv/utf8d_back.sv]
// Back end of the UTF-8 decoder: sequence state, value checks and the
// output register. Depends on utf8d_pkg.
`default_nettype none

module utf8d_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             item_valid_i,
  output logic             item_ready_o,
  input  utf8d_pkg::item_t item_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [20:0]      code_point_o,
  output logic             status_o,
  output logic [2:0]       seq_length_o
);
  import utf8d_pkg::*;

  logic [CpW-1:0]  pv_q, pv_d;
  logic [LenW-1:0] seen_q, seen_d, exp_q, exp_d;
  logic            out_valid_q, out_valid_d;
  logic [CpW-1:0]  cp_q, cp_d;
  logic            bad_q, bad_d;
  logic [LenW-1:0] len_q, len_d;

  logic            pop, emit;
  logic [CpW-1:0]  shifted, minimum;
  logic [LenW-1:0] seen_next;

  assign item_ready_o = !out_valid_q || out_ready_i;
  assign pop          = item_valid_i && item_ready_o;
  assign shifted      = {pv_q[CpW-7:0], item_i.data[5:0]};
  assign seen_next    = seen_q + LenW'(1);

  always_comb begin
    case (exp_q)
      Len2:    minimum = Min2Byte;
      Len3:    minimum = Min3Byte;
      default: minimum = Min4Byte;
    endcase
  end

  always_comb begin
    pv_d   = pv_q;
    seen_d = seen_q;
    exp_d  = exp_q;
    emit   = 1'b0;
    cp_d   = cp_q;
    bad_d  = bad_q;
    len_d  = len_q;
    if (pop) begin
      if (item_i.cmd) begin
        pv_d   = '0;
        seen_d = '0;
        exp_d  = '0;
      end else if (seen_q == '0) begin
        case (item_i.kind)
          KIND_ASCII: begin
            emit  = 1'b1;
            cp_d  = CpW'(item_i.data);
            bad_d = 1'b0;
            len_d = Len1;
          end
          KIND_LEAD2: begin
            pv_d   = CpW'(item_i.data[4:0]);
            exp_d  = Len2;
            seen_d = Len1;
          end
          KIND_LEAD3: begin
            pv_d   = CpW'(item_i.data[3:0]);
            exp_d  = Len3;
            seen_d = Len1;
          end
          KIND_LEAD4: begin
            pv_d   = CpW'(item_i.data[2:0]);
            exp_d  = Len4;
            seen_d = Len1;
          end
          default: begin
            // A stray continuation or an invalid lead byte.
            emit   = 1'b1;
            cp_d   = '0;
            bad_d  = 1'b1;
            len_d  = Len1;
            pv_d   = '0;
            exp_d  = '0;
          end
        endcase
      end else if (item_i.kind != KIND_CONT) begin
        emit   = 1'b1;
        cp_d   = '0;
        bad_d  = 1'b1;
        len_d  = seen_next;
        pv_d   = '0;
        seen_d = '0;
        exp_d  = '0;
      end else if (seen_next < exp_q) begin
        pv_d   = shifted;
        seen_d = seen_next;
      end else begin
        emit   = 1'b1;
        len_d  = exp_q;
        pv_d   = '0;
        seen_d = '0;
        exp_d  = '0;
        if (shifted < minimum || shifted > CpMax ||
            (shifted >= SurrLo && shifted <= SurrHi)) begin
          cp_d  = '0;
          bad_d = 1'b1;
        end else begin
          cp_d  = shifted;
          bad_d = 1'b0;
        end
      end
    end
  end

  always_comb begin
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q        <= '0;
      seen_q      <= '0;
      exp_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pv_q        <= pv_d;
      seen_q      <= seen_d;
      exp_q       <= exp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cp_q  <= cp_d;
    bad_q <= bad_d;
    len_q <= len_d;
  end

  assign out_valid_o  = out_valid_q;
  assign code_point_o = cp_q;
  assign status_o     = bad_q;
  assign seq_length_o = len_q;

endmodule

`default_nettype wire

[sv/utf8_to_utf32_decoder.sv]
// Top level of the validating UTF-8 to UTF-32 decoder.
// Depends on utf8d_pkg, utf8d_front, utf8d_fifo and utf8d_back.
//
//   Channel | Direction | Handshake            | Payload
//   --------+-----------+----------------------+-----------------------------------
//   in      | input     | in_valid_i/in_ready_o| command_i, data_byte_i
//   out     | output    | out_valid_o/out_ready_i | code_point_o, status_o, seq_length_o
//
// One byte transfer is taken per cycle while the queue is not full; the
// sequence state in the back end updates once per byte.
// A byte's transfer writes it into the queue, and the back-end update then
// moves its result into the result register when nothing stalls.
// Reset is asynchronous and clears the queue, the sequence state and the
// output valid flag at once; there is no clearing pass.
// A stalled output holds its result while the queue of QueueDepth entries
// keeps taking bytes; in_ready_o drops only when that queue is full.
`default_nettype none

module utf8_to_utf32_decoder #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        command_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [20:0] code_point_o,
  output logic        status_o,
  output logic [2:0]  seq_length_o
);
  import utf8d_pkg::*;

  // Classified byte entering the queue and the one leaving it.
  item_t front_item, back_item;
  logic  back_valid, back_ready;

  // The front end only classifies; the class travels with the byte so the
  // back end never decodes ranges itself.
  utf8d_front u_front (
    .command_i  (command_i),
    .data_byte_i(data_byte_i),
    .item_o     (front_item)
  );

  utf8d_fifo #(
    .Depth(QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(in_valid_i),
    .push_ready_o(in_ready_o),
    .push_item_i (front_item),
    .pop_valid_o (back_valid),
    .pop_ready_i (back_ready),
    .pop_item_o  (back_item)
  );

  // The back end pulls a byte whenever its result register is free or is
  // being emptied in the same cycle, so a byte enters as the last result leaves.
  utf8d_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(back_valid),
    .item_ready_o(back_ready),
    .item_i      (back_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .code_point_o(code_point_o),
    .status_o    (status_o),
    .seq_length_o(seq_length_o)
  );

endmodule

`default_nettype wire

[sv/utf8d_checker.sv]
// Port-level checks for the UTF-8 decoder and the bind that attaches them.
// Depends on utf8_to_utf32_decoder only through its port names.
`default_nettype none

module utf8d_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        command_i,
  input logic [7:0]  data_byte_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [20:0] code_point_o,
  input logic        status_o,
  input logic [2:0]  seq_length_o
);

  // A waiting byte transfer stays offered with the same payload.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=>
      in_valid_i && $stable(command_i) && $stable(data_byte_i))
    else $error("waiting byte transfer changed or vanished");

  // A stalled result stays offered with the same payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(code_point_o) && $stable(status_o) &&
      $stable(seq_length_o))
    else $error("stalled result changed or vanished");

  // An error carries a zero code point, and every length is one to four.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!status_o || code_point_o == 21'd0) &&
      seq_length_o >= 3'd1 && seq_length_o <= 3'd4)
    else $error("bad error payload or length");

  // A valid character is a scalar value: not a surrogate, not above the top.
  a_scalar: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !status_o |->
      code_point_o <= 21'h10FFFF &&
      !(code_point_o >= 21'h00D800 && code_point_o <= 21'h00DFFF))
    else $error("decoded value is not a scalar value");

  // Valid characters use the shortest form for their length.
  a_shortest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !status_o |->
      (seq_length_o == 3'd1 && code_point_o < 21'h80) ||
      (seq_length_o == 3'd2 && code_point_o >= 21'h80 && code_point_o < 21'h800) ||
      (seq_length_o == 3'd3 && code_point_o >= 21'h800 && code_point_o < 21'h10000) ||
      (seq_length_o == 3'd4 && code_point_o >= 21'h10000))
    else $error("length does not match the decoded value");

endmodule

bind utf8_to_utf32_decoder utf8d_checker u_checker (.*);

`default_nettype wire

[sim/utf8_to_utf32_decoder_tb.sv]
// Self-checking testbench for the UTF-8 to UTF-32 decoder.
// Depends on utf8d_pkg and utf8_to_utf32_decoder. Bytes go in through a random
// bursty sender, and every decoded character or illegal-sequence report is checked.
`timescale 1ns / 1ps

module utf8_to_utf32_decoder_tb;

  import utf8d_pkg::*;

  // Command and status codes of the byte and result channels.
  localparam logic CmdData      = 1'b0;
  localparam logic CmdClear     = 1'b1;
  localparam logic StatusOk     = 1'b0;
  localparam logic StatusIllegal = 1'b1;

  // Cycles with no transfer on either channel before the run is declared hung.
  localparam int unsigned IdleLimit = 2000;
  // Extra cycles waited at the end, after every expected result has arrived.
  localparam int unsigned DrainCycles = 8;

  // The short boundary stream: {command, byte} pairs, first element sent first.
  localparam logic [0:24][8:0] BoundaryItems = {
    {CmdData, 8'h00},                                      // NUL byte
    {CmdData, 8'hC2}, {CmdData, 8'h80},                    // smallest two-byte form
    {CmdData, 8'hF4}, {CmdData, 8'h8F}, {CmdData, 8'hBF},
    {CmdData, 8'hBF},                                      // largest scalar value
    {CmdData, 8'h80}, {CmdData, 8'hFF},                    // stray continuation, bad lead
    {CmdData, 8'hE0}, {CmdData, 8'h9F}, {CmdData, 8'hBF},  // overlong three-byte form
    {CmdData, 8'hED}, {CmdData, 8'hA0}, {CmdData, 8'h80},  // surrogate
    {CmdData, 8'hF4}, {CmdData, 8'h90}, {CmdData, 8'h80},
    {CmdData, 8'h80},                                      // above the Unicode range
    {CmdData, 8'hC2}, {CmdData, 8'h41},                    // missing continuation
    {CmdData, 8'hE1}, {CmdData, 8'h80}, {CmdClear, 8'hFF}, // sequence cut by a clear
    {CmdData, 8'h41}
  };

  typedef struct packed {
    logic [CpW-1:0]  code_point;
    logic            status;
    logic [LenW-1:0] seq_length;
  } char_result_t;

  // Encoded bytes of one character, index 0 goes out first.
  typedef logic [0:3][7:0] utf8_bytes_t;

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_COIN,
    RX_PERIODIC,
    RX_SPARSE
  } rx_mode_e;

  // Every input of the block starts at a known value.
  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        command_i   = CmdData;
  logic [7:0]  data_byte_i = 8'h00;
  logic        out_ready_i = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [20:0] code_point_o;
  logic        status_o;
  logic [2:0]  seq_length_o;

  // Handshakes and result fields, sampled at the falling edge and used at the
  // next rising edge, so nothing depends on event order at the clock edge.
  logic            in_take  = 1'b0;
  logic            out_take = 1'b0;
  logic [CpW-1:0]  seen_cp;
  logic            seen_status;
  logic [LenW-1:0] seen_len;

  // Decoder state as predicted by the testbench.
  logic [CpW-1:0]  dec_partial = '0;
  logic [LenW-1:0] dec_seen    = '0;
  logic [LenW-1:0] dec_len     = '0;

  char_result_t expected_chars[$];

  int unsigned fail_count  = 0;
  int unsigned bytes_sent  = 0;
  int unsigned clears_sent = 0;
  int unsigned chars_ok    = 0;
  int unsigned chars_bad   = 0;
  int unsigned burst_left  = 0;
  int unsigned idle_cycles = 0;
  int unsigned rx_cycle    = 0;
  rx_mode_e    rx_mode     = RX_ALWAYS;

  utf8_to_utf32_decoder i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .data_byte_i  (data_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .code_point_o (code_point_o),
    .status_o     (status_o),
    .seq_length_o (seq_length_o)
  );

  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic void push_result(input logic [CpW-1:0] cp, input logic st,
                                      input logic [LenW-1:0] len);
    char_result_t res;
    res.code_point = cp;
    res.status     = st;
    res.seq_length = len;
    expected_chars.push_back(res);
  endfunction

  function automatic void clear_decoder();
    dec_partial = '0;
    dec_seen    = '0;
    dec_len     = '0;
  endfunction

  // Advances the predicted decoder by one accepted byte transfer and queues the
  // result that the byte causes, if any.
  function automatic void predict_decode(input logic cmd, input logic [7:0] b);
    logic [CpW-1:0]  value;
    logic [CpW-1:0]  floor_cp;
    logic [LenW-1:0] len;
    if (cmd == CmdClear) begin
      clear_decoder();
      return;
    end
    if (dec_seen == '0) begin
      // Idle: the byte must be ASCII or a legal lead byte.
      if (b < 8'h80) begin
        push_result({13'd0, b}, StatusOk, Len1);
      end else if (b >= 8'hC2 && b <= 8'hDF) begin
        dec_partial = {16'd0, b[4:0]};
        dec_len     = Len2;
        dec_seen    = 3'd1;
      end else if (b >= 8'hE0 && b <= 8'hEF) begin
        dec_partial = {17'd0, b[3:0]};
        dec_len     = Len3;
        dec_seen    = 3'd1;
      end else if (b >= 8'hF0 && b <= 8'hF4) begin
        dec_partial = {18'd0, b[2:0]};
        dec_len     = Len4;
        dec_seen    = 3'd1;
      end else begin
        clear_decoder();
        push_result('0, StatusIllegal, Len1);
      end
      return;
    end
    // Inside a sequence anything but a continuation byte is dropped as an error.
    if (b[7:6] != 2'b10) begin
      len = dec_seen + 3'd1;
      clear_decoder();
      push_result('0, StatusIllegal, len);
      return;
    end
    dec_partial = {dec_partial[14:0], b[5:0]};
    dec_seen    = dec_seen + 3'd1;
    if (dec_seen < dec_len) begin
      return;
    end
    value = dec_partial;
    len   = dec_len;
    case (len)
      Len2:    floor_cp = Min2Byte;
      Len3:    floor_cp = Min3Byte;
      default: floor_cp = Min4Byte;
    endcase
    clear_decoder();
    if (value < floor_cp || value > CpMax || (value >= SurrLo && value <= SurrHi)) begin
      push_result('0, StatusIllegal, len);
    end else begin
      push_result(value, StatusOk, len);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Encodes the low bits of cp in the form of the given length, without any
  // check, so out-of-range values give overlong or illegal byte patterns.
  function automatic utf8_bytes_t encode_utf8(input logic [CpW-1:0] cp, input int len);
    utf8_bytes_t enc;
    enc = '0;
    case (len)
      1: enc[0] = {1'b0, cp[6:0]};
      2: begin
        enc[0] = {3'b110, cp[10:6]};
        enc[1] = {2'b10, cp[5:0]};
      end
      3: begin
        enc[0] = {4'b1110, cp[15:12]};
        enc[1] = {2'b10, cp[11:6]};
        enc[2] = {2'b10, cp[5:0]};
      end
      default: begin
        enc[0] = {5'b11110, cp[20:18]};
        enc[1] = {2'b10, cp[17:12]};
        enc[2] = {2'b10, cp[11:6]};
        enc[3] = {2'b10, cp[5:0]};
      end
    endcase
    return enc;
  endfunction

  // A random legal scalar value whose shortest form has the given length.
  function automatic logic [CpW-1:0] pick_scalar(input int len);
    logic [CpW-1:0] cp;
    case (len)
      1: cp = CpW'($urandom_range(0, Min2Byte - 1));
      2: cp = CpW'($urandom_range(Min2Byte, Min3Byte - 1));
      3: begin
        cp = CpW'($urandom_range(Min3Byte, Min4Byte - 1));
        // Fold surrogates up into 0xF800-0xFFFF, which is legal.
        if (cp >= SurrLo && cp <= SurrHi) begin
          cp = cp ^ 21'h002000;
        end
      end
      default: cp = CpW'($urandom_range(Min4Byte, CpMax));
    endcase
    return cp;
  endfunction

  // Sends one byte transfer. The sender works in bursts; when a burst is used
  // up it drops valid for a random gap first. Valid stays high, with the
  // payload unchanged, until the transfer happens.
  task automatic send_byte(input logic cmd, input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 20);
    end
    in_valid_i  <= 1'b1;
    command_i   <= cmd;
    data_byte_i <= b;
    do @(posedge clk_i); while (!in_take);
    burst_left--;
    bytes_sent++;
    if (cmd == CmdClear) begin
      clears_sent++;
    end
    predict_decode(cmd, b);
  endtask

  task automatic send_bytes(input utf8_bytes_t enc, input int count);
    for (int i = 0; i < count; i++) begin
      send_byte(CmdData, enc[i]);
    end
  endtask

  // Holds the sender off until every queued result has been seen.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes and special cases of the decoder, in one short stream.
  task automatic test_boundaries();
    for (int i = 0; i < 25; i++) begin
      send_byte(BoundaryItems[i][8], BoundaryItems[i][7:0]);
    end
  endtask

  // Well-formed text of random characters of all lengths. Halfway through the
  // sender stops until the output side has caught up completely.
  task automatic test_valid_text(input int unsigned n_bytes);
    int unsigned stop_at;
    int unsigned half;
    int          len;
    logic        paused;
    stop_at = bytes_sent + n_bytes;
    half    = bytes_sent + n_bytes / 2;
    paused  = 1'b0;
    while (bytes_sent < stop_at) begin
      len = $urandom_range(1, 4);
      send_bytes(encode_utf8(pick_scalar(len), len), len);
      if (!paused && bytes_sent >= half) begin
        wait_drained();
        paused = 1'b1;
      end
    end
  endtask

  // Half well-formed characters, half broken input: bad values in full-length
  // forms, cut sequences, stray continuation bytes, noise and clear commands.
  task automatic test_malformed_text(input int unsigned n_bytes);
    int unsigned    stop_at;
    int             len;
    int             k;
    logic [CpW-1:0] cp;
    logic [7:0]     b;
    utf8_bytes_t    enc;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      len = $urandom_range(2, 4);
      k   = $urandom_range(1, len - 1);
      enc = encode_utf8(pick_scalar(len), len);
      b   = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          len = $urandom_range(1, 4);
          send_bytes(encode_utf8(pick_scalar(len), len), len);
        end
        5: begin
          case ($urandom_range(0, 2))
            0: begin
              // Overlong: the value fits in a shorter form.
              case (len)
                2:       cp = CpW'($urandom_range(0, Min2Byte - 1));
                3:       cp = CpW'($urandom_range(0, Min3Byte - 1));
                default: cp = CpW'($urandom_range(0, Min4Byte - 1));
              endcase
            end
            1: begin
              // Above the Unicode range for four bytes, surrogates otherwise.
              if (len == 4) begin
                cp = CpW'($urandom_range(CpMax + 1, 21'h1FFFFF));
              end else begin
                cp = CpW'($urandom_range(SurrLo, SurrHi));
              end
            end
            default: cp = CpW'($urandom);
          endcase
          send_bytes(encode_utf8(cp, len), len);
        end
        6: begin
          // Cut sequence followed by a byte that is not a continuation.
          send_bytes(enc, k);
          if (b[7:6] == 2'b10) begin
            b[6] = 1'b1;
          end
          send_byte(CmdData, b);
        end
        7: begin
          send_bytes(enc, k);
          send_byte(CmdClear, b);
        end
        8: send_byte(CmdData, b);
        default: begin
          if ($urandom_range(0, 1) == 0) begin
            send_byte(CmdData, {2'b10, b[5:0]});
          end else begin
            send_byte(CmdClear, b);
          end
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver, sampling, checking and watchdog
  // ---------------------------------------------------------------------------

  // The receiver switches at random between four stall patterns.
  always @(posedge clk_i) begin
    rx_cycle = rx_cycle + 1;
    if (rx_cycle % 256 == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
    end
    case (rx_mode)
      RX_ALWAYS:   out_ready_i <= 1'b1;
      RX_COIN:     out_ready_i <= 1'($urandom_range(0, 1));
      RX_PERIODIC: out_ready_i <= (rx_cycle % 7) < 3;
      default:     out_ready_i <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(negedge clk_i) begin
    in_take     = rst_ni && in_valid_i && in_ready_o;
    out_take    = rst_ni && out_valid_o && out_ready_i;
    seen_cp     = code_point_o;
    seen_status = status_o;
    seen_len    = seq_length_o;
  end

  task automatic compare_field(input string field, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      fail_count++;
    end
  endtask

  // Each result transfer is matched against the oldest prediction.
  always @(posedge clk_i) begin
    char_result_t want;
    if (out_take) begin
      if (expected_chars.size() == 0) begin
        $error("result with nothing expected: code_point 0x%0h status %0d seq_length %0d",
               seen_cp, seen_status, seen_len);
        fail_count++;
      end else begin
        want = expected_chars.pop_front();
        compare_field("code_point", 32'(want.code_point), 32'(seen_cp));
        compare_field("status", 32'(want.status), 32'(seen_status));
        compare_field("seq_length", 32'(want.seq_length), 32'(seen_len));
        if (want.status == StatusOk) begin
          chars_ok++;
        end else begin
          chars_bad++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || in_take || out_take) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
    end
    if (idle_cycles == IdleLimit) begin
      $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
               IdleLimit, expected_chars.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_boundaries();
    wait_drained();
    test_valid_text(700);
    wait_drained();
    test_malformed_text(700);

    // Let the last results come out, then give the block a few more cycles
    // in which nothing further may appear.
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (expected_chars.size() != 0) begin
      $error("%0d expected results never arrived", expected_chars.size());
      fail_count++;
    end

    $display("Sent %0d byte transfers (%0d clear commands); checked %0d characters and",
             bytes_sent, clears_sent, chars_ok);
    $display("%0d illegal-sequence reports under random sender gaps and receiver stalls.",
             chars_bad);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[sim.f]
sv/utf8d_pkg.sv
sv/utf8d_front.sv
sv/utf8d_fifo.sv
sv/utf8d_back.sv
sv/utf8_to_utf32_decoder.sv
sv/utf8d_checker.sv
sim/utf8_to_utf32_decoder_tb.sv
